FILE: sv/dmtp_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and character constants for the decimal amount parser.
package dmtp_pkg;

    localparam int UNITS_WIDTH_DEFAULT = 64;
    localparam int UNITS_W             = 64;
    localparam int SCALE_W             = 5;

    localparam logic [SCALE_W-1:0] MAX_SCALE_RESET = 5'd2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_EMPTY_AMOUNT   = 3'd1,
        ST_EMPTY_CURRENCY = 3'd2,
        ST_MISSING_DIGITS = 3'd3,
        ST_INVALID_CHAR   = 3'd4,
        ST_TWO_POINTS     = 3'd5,
        ST_TOO_MANY_FRAC  = 3'd6,
        ST_OVERFLOW       = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        PH_LEAD = 2'd0,
        PH_BODY = 2'd1,
        PH_TAIL = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       no_char;
        logic       last;
        logic       currency_blank;
    } in_word_t;

    typedef struct packed {
        status_t                    status;
        logic signed [UNITS_W-1:0]  units;
        logic        [SCALE_W-1:0]  scale;
    } out_word_t;

    typedef struct packed {
        status_t              status;
        logic                 negative;
        logic [SCALE_W-1:0]   scale;
    } result_ctl_t;

endpackage

FILE: sv/decimal_money_text_parser.sv
`timescale 1ns / 1ps
// A word accepted into the input register updates the parse state as it leaves that
// register, when not held back; its result (last words only) is shown from then on.
// Throughput: one word per cycle, limited only by the result register being taken.
// Reset (rst_n low, asynchronous) empties both registers, clears the text state
// and sets max_scale to 2; no clearing pass follows.
module decimal_money_text_parser #(
    parameter int UNITS_WIDTH = dmtp_pkg::UNITS_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [dmtp_pkg::SCALE_W-1:0]  cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  dmtp_pkg::in_word_t            in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output dmtp_pkg::out_word_t           out_data
);
    import dmtp_pkg::*;

    localparam int MAG_W = UNITS_WIDTH - 1;

    // Held word between the input register and the parse logic.
    logic        hold_valid;
    in_word_t    hold_data;

    // A word advances when it is not a last word, or when the result
    // register can take the result it produces.
    logic        res_ready;
    logic        advance;
    logic        res_load;

    result_ctl_t      res_ctl;
    logic [MAG_W-1:0] res_mag;

    assign advance  = hold_valid && (!hold_data.last || res_ready);
    assign res_load = advance && hold_data.last;

    // Input register: holds the next character word, lets a new one in each cycle unless stalled.
    dmtp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_data  (hold_data)
    );

    // Parse core: classify the character, step the text state, form the result.
    dmtp_core #(
        .UNITS_WIDTH (UNITS_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (advance),
        .word        (hold_data),
        .res_ctl     (res_ctl),
        .res_mag     (res_mag)
    );

    // Result register: hold the result until the sink takes it, apply the sign.
    dmtp_out_reg #(
        .UNITS_WIDTH (UNITS_WIDTH)
    ) u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_load  (res_load),
        .res_ctl   (res_ctl),
        .res_mag   (res_mag),
        .res_ready (res_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: sv/dmtp_in_reg.sv
`timescale 1ns / 1ps
// Input register stage holding one word ahead of the parse logic.
module dmtp_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  dmtp_pkg::in_word_t in_data,
    input  logic              advance,
    output logic              hold_valid,
    output dmtp_pkg::in_word_t hold_data
);
    import dmtp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t data_reg;
    logic     load;

    // Stall only while a held word cannot move on this cycle.
    assign in_stall = valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= in_data;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_data  = data_reg;

endmodule

FILE: sv/dmtp_core.sv
`timescale 1ns / 1ps
// Per-character parse state, its registered update and the result it yields on last.
module dmtp_core #(
    parameter int UNITS_WIDTH = dmtp_pkg::UNITS_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [dmtp_pkg::SCALE_W-1:0]  cfg_wr_data,
    input  logic                          fire,
    input  dmtp_pkg::in_word_t            word,
    output dmtp_pkg::result_ctl_t         res_ctl,
    output logic [UNITS_WIDTH-2:0]        res_mag
);
    import dmtp_pkg::*;

    localparam int MAG_W = UNITS_WIDTH - 1;

    logic [SCALE_W-1:0] max_scale_reg;

    phase_t             phase_reg,  phase_upd,  phase_next;
    logic [MAG_W-1:0]   mag_reg,    mag_upd,    mag_next;
    logic [MAG_W-1:0]   mbz_reg,    mbz_upd,    mbz_next;
    logic [SCALE_W-1:0] frac_reg,   frac_upd,   frac_next;
    logic [SCALE_W-1:0] tz_reg,     tz_upd,     tz_next;
    logic               digit_reg,  digit_upd,  digit_next;
    logic               point_reg,  point_upd,  point_next;
    logic               neg_reg,    neg_upd,    neg_next;
    status_t            err_reg,    err_upd,    err_next;

    logic [7:0]         c;
    logic               take;
    logic               sp;
    logic               is_sign;
    logic               is_point;
    logic               is_digit;
    logic [3:0]         digit;
    logic [7:0]         digit_wide;
    logic [MAG_W+3:0]   prod;
    logic               ovf;
    logic               body_go;
    status_t            status;

    assign c          = word.char_code;
    assign take       = !word.no_char;
    assign sp         = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    assign is_sign    = (c == CHAR_PLUS) || (c == CHAR_MINUS);
    assign is_point   = (c == CHAR_POINT);
    assign is_digit   = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign digit_wide = c - CHAR_ZERO;
    assign digit      = digit_wide[3:0];

    // Times ten as 8m + 2m; anything above the magnitude range is overflow.
    assign prod = {3'b000, mag_reg, 1'b0} + {1'b0, mag_reg, 3'b000}
                + {{MAG_W{1'b0}}, digit};
    assign ovf  = |prod[MAG_W+3:MAG_W];

    assign body_go = take && !sp
                   && ((phase_reg == PH_LEAD && !is_sign) || phase_reg == PH_BODY);

    always_comb
    begin
        phase_upd = phase_reg;
        unique case (phase_reg)
            PH_LEAD:
            begin
                if (take && !sp)
                begin
                    phase_upd = PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (take && sp)
                begin
                    phase_upd = PH_TAIL;
                end
            end
            PH_TAIL:
            begin
                phase_upd = PH_TAIL;
            end
            default:
            begin
                phase_upd = PH_LEAD;
            end
        endcase
    end

    always_comb
    begin
        mag_upd   = mag_reg;
        mbz_upd   = mbz_reg;
        frac_upd  = frac_reg;
        tz_upd    = tz_reg;
        digit_upd = digit_reg;
        point_upd = point_reg;
        neg_upd   = neg_reg;
        err_upd   = err_reg;

        if (take && !sp && phase_reg == PH_LEAD && is_sign)
        begin
            neg_upd = (c == CHAR_MINUS);
        end

        if (take && !sp && phase_reg == PH_TAIL && err_reg == ST_OK)
        begin
            err_upd = ST_INVALID_CHAR;
        end

        if (body_go && err_reg == ST_OK)
        begin
            if (is_point)
            begin
                if (point_reg)
                begin
                    err_upd = ST_TWO_POINTS;
                end
                else
                begin
                    point_upd = 1'b1;
                end
            end
            else if (!is_digit)
            begin
                err_upd = ST_INVALID_CHAR;
            end
            else
            begin
                digit_upd = 1'b1;
                if (point_reg && frac_reg >= max_scale_reg)
                begin
                    err_upd = ST_TOO_MANY_FRAC;
                end
                else
                begin
                    if (point_reg)
                    begin
                        frac_upd = frac_reg + 1'b1;
                    end
                    if (ovf)
                    begin
                        err_upd = ST_OVERFLOW;
                    end
                    else
                    begin
                        if (point_reg)
                        begin
                            if (digit == 4'd0)
                            begin
                                // Remember the value before a run of fraction zeros.
                                if (tz_reg == '0)
                                begin
                                    mbz_upd = mag_reg;
                                end
                                tz_upd = tz_reg + 1'b1;
                            end
                            else
                            begin
                                tz_upd = '0;
                            end
                        end
                        mag_upd = prod[MAG_W-1:0];
                    end
                end
            end
        end
    end

    // Drop all text state after the last word.
    always_comb
    begin
        if (word.last)
        begin
            phase_next = PH_LEAD;
            mag_next   = '0;
            mbz_next   = '0;
            frac_next  = '0;
            tz_next    = '0;
            digit_next = 1'b0;
            point_next = 1'b0;
            neg_next   = 1'b0;
            err_next   = ST_OK;
        end
        else
        begin
            phase_next = phase_upd;
            mag_next   = mag_upd;
            mbz_next   = mbz_upd;
            frac_next  = frac_upd;
            tz_next    = tz_upd;
            digit_next = digit_upd;
            point_next = point_upd;
            neg_next   = neg_upd;
            err_next   = err_upd;
        end
    end

    always_comb
    begin
        if (phase_upd == PH_LEAD)
        begin
            status = ST_EMPTY_AMOUNT;
        end
        else if (word.currency_blank)
        begin
            status = ST_EMPTY_CURRENCY;
        end
        else if (err_upd != ST_OK)
        begin
            status = err_upd;
        end
        else if (!digit_upd)
        begin
            status = ST_MISSING_DIGITS;
        end
        else
        begin
            status = ST_OK;
        end
    end

    always_comb
    begin
        res_ctl.status   = status;
        res_ctl.negative = 1'b0;
        res_ctl.scale    = '0;
        res_mag          = '0;
        if (status == ST_OK && mag_upd != '0)
        begin
            res_ctl.negative = neg_upd;
            if (tz_upd != '0)
            begin
                res_mag       = mbz_upd;
                res_ctl.scale = frac_upd - tz_upd;
            end
            else
            begin
                res_mag       = mag_upd;
                res_ctl.scale = frac_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_scale_reg <= MAX_SCALE_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_scale_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            mag_reg   <= '0;
            mbz_reg   <= '0;
            frac_reg  <= '0;
            tz_reg    <= '0;
            digit_reg <= 1'b0;
            point_reg <= 1'b0;
            neg_reg   <= 1'b0;
            err_reg   <= ST_OK;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            mag_reg   <= mag_next;
            mbz_reg   <= mbz_next;
            frac_reg  <= frac_next;
            tz_reg    <= tz_next;
            digit_reg <= digit_next;
            point_reg <= point_next;
            neg_reg   <= neg_next;
            err_reg   <= err_next;
        end
    end

endmodule

FILE: sv/dmtp_out_reg.sv
`timescale 1ns / 1ps
// Result register with the output handshake and the final sign application.
module dmtp_out_reg #(
    parameter int UNITS_WIDTH = dmtp_pkg::UNITS_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   res_load,
    input  dmtp_pkg::result_ctl_t  res_ctl,
    input  logic [UNITS_WIDTH-2:0] res_mag,
    output logic                   res_ready,
    output logic                   out_valid,
    input  logic                   out_stall,
    output dmtp_pkg::out_word_t    out_data
);
    import dmtp_pkg::*;

    localparam int MAG_W = UNITS_WIDTH - 1;

    logic             valid_reg;
    logic             valid_next;
    result_ctl_t      ctl_reg;
    logic [MAG_W-1:0] mag_reg;
    logic [UNITS_W-1:0] mag_ext;

    assign res_ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            ctl_reg <= res_ctl;
            mag_reg <= res_mag;
        end
    end

    assign mag_ext = {{(UNITS_W-MAG_W){1'b0}}, mag_reg};

    always_comb
    begin
        out_data.status = ctl_reg.status;
        out_data.scale  = ctl_reg.scale;
        out_data.units  = ctl_reg.negative ? -mag_ext : mag_ext;
    end

    assign out_valid = valid_reg;

endmodule

FILE: sv/dmtp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the parser, bound to the top level.
module dmtp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input dmtp_pkg::out_word_t           out_data
);
    import dmtp_pkg::*;

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // An error status carries no amount.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.units == '0 && out_data.scale == '0)
        else $error("error result with non-zero amount or scale");

    // A zero amount has scale zero.
    a_zero_scale: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.units == '0 |-> out_data.scale == '0)
        else $error("zero amount with non-zero scale");

    // Input stall rises only while a word is pending on the result side.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

endmodule

bind decimal_money_text_parser dmtp_checker u_dmtp_checker (.*);
